### src/flng_pkg.sv
// Shared constants, types and codes for the interpolated feedback flanger.
package flng_pkg;

  localparam int DEPTH     = 4096;
  localparam int FRAC_BITS = 8;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int LEN_W     = 13;
  localparam int DELAY_W   = 21;
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int POS_W     = ADDR_W + FRAC_BITS;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(DEPTH);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(DEPTH);

  // Register index, taken from paddr[2]
  localparam logic REG_LINE_LENGTH   = 1'b0;
  localparam logic REG_FEEDBACK_GAIN = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0]         len;   // clamped to [2, DEPTH]
    logic signed [GAIN_W-1:0] gain;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RDB,
    ST_INT,
    ST_FB,
    ST_WR
  } state_t;

endpackage

### src/flng_if.sv
// Valid/ready channel interfaces for input and result beats.
interface flng_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [flng_pkg::SAMPLE_W-1:0]    sample_in;
  logic        [flng_pkg::DELAY_W-1:0]     delay_samples;

  modport source (output valid, output sample_in, output delay_samples, input ready);
  modport sink   (input valid, input sample_in, input delay_samples, output ready);
endinterface

interface flng_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [flng_pkg::SAMPLE_W-1:0]    sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

### src/interpolated_feedback_flanger_core.sv
// Interpolated feedback flanger: circular delay line in one RAM, read twice, written once.
// Flow: an accepted beat is processed by two reads through the single RAM read port,
// the interpolation and feedback multiplies and the write-back, and no new beat is taken
// until its write-back; the result is registered at the write-back. A result not yet taken
// holds the write-back state until the result register frees up.
// Reset (rst_n, synchronous): a clearing pass zeroes all 4096 RAM entries, one per cycle,
// during which no input beat is taken; config writes are accepted throughout.
module interpolated_feedback_flanger_core (
  input  logic                          clk,
  input  logic                          rst_n,
  flng_in_if.sink                       in_ch,
  flng_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [flng_pkg::PADDR_W-1:0]  paddr,
  input  logic [flng_pkg::PDATA_W-1:0]  pwdata,
  output logic [flng_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int AW = flng_pkg::ADDR_W;
  localparam int FB = flng_pkg::FRAC_BITS;
  localparam int SW = flng_pkg::SAMPLE_W;
  localparam int DW = flng_pkg::DELAY_W;
  localparam int LW = flng_pkg::LEN_W;
  localparam int PW = flng_pkg::POS_W;

  flng_pkg::cfg_t   cfg;
  flng_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]        clr_cnt_r;
  logic [AW-1:0]        wp_r;
  logic [AW-1:0]        wpw_r;
  logic [AW-1:0]        rpi_r;
  logic [FB-1:0]        frac_r;
  logic signed [SW-1:0] sample_r;
  logic signed [SW-1:0] a_r;
  logic signed [SW-1:0] y_r;
  logic signed [2*SW-1:0] fbp_r;
  logic                 out_valid_r;
  logic signed [SW-1:0] out_data_r;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;

  // read address math
  logic [DW-1:0] len_q;
  logic [DW-1:0] vdt;
  logic [AW-1:0] wp_eff;
  logic [DW-1:0] pos_q;
  logic [DW-1:0] rp_full;
  logic [AW-1:0] rpi_b;

  // datapath
  logic signed [SW:0]     diff;
  logic signed [SW+FB:0]  iprod;
  logic signed [SW+1:0]   y_full;
  logic signed [SW+1:0]   acc;
  logic signed [SW-1:0]   wb_val;
  logic                   wr_go;
  logic                   in_acc;
  logic                   out_take;

  flng_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  flng_ram #(
    .WIDTH (SW),
    .DEPTH (flng_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read position: write position minus clamped delay, wrapped into [0, len_q)
  always_comb begin
    len_q   = {cfg.len, FB'(0)};
    vdt     = (in_ch.delay_samples > len_q) ? len_q : in_ch.delay_samples;
    wp_eff  = ({1'b0, wp_r} >= cfg.len) ? '0 : wp_r;
    pos_q   = DW'({wp_eff, FB'(0)});
    rp_full = (pos_q >= vdt) ? (pos_q - vdt) : (pos_q + len_q - vdt);
    rpi_b   = ({1'b0, rpi_r} == (cfg.len - LW'(1))) ? '0 : (rpi_r + AW'(1));
  end

  // Interpolation and feedback arithmetic
  always_comb begin
    diff   = $signed({ram_rdata[SW-1], ram_rdata}) - $signed({a_r[SW-1], a_r});
    iprod  = $signed({1'b0, frac_r}) * diff;
    y_full = (SW+2)'(a_r) + (SW+2)'(iprod >>> FB);
    acc    = (SW+2)'(sample_r) + (SW+2)'(fbp_r >>> (SW-1));
    if (acc > (SW+2)'(32767)) begin
      wb_val = 16'sh7fff;
    end else if (acc < -(SW+2)'(32768)) begin
      wb_val = -16'sh8000;
    end else begin
      wb_val = acc[SW-1:0];
    end
  end

  assign out_take = out_valid_r && out_ch.ready;
  assign wr_go    = !out_valid_r || out_ch.ready;
  assign in_acc   = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= flng_pkg::ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = wpw_r;
    ram_wdata   = wb_val;
    ram_raddr   = rp_full[PW-1:FB];
    case (state_r)
      flng_pkg::ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
        if (clr_cnt_r == AW'(flng_pkg::DEPTH - 1)) begin
          state_nxt = flng_pkg::ST_IDLE;
        end
      end
      flng_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = flng_pkg::ST_RDB;
        end
      end
      flng_pkg::ST_RDB: begin
        ram_raddr = rpi_b;
        state_nxt = flng_pkg::ST_INT;
      end
      flng_pkg::ST_INT: begin
        state_nxt = flng_pkg::ST_FB;
      end
      flng_pkg::ST_FB: begin
        state_nxt = flng_pkg::ST_WR;
      end
      flng_pkg::ST_WR: begin
        if (wr_go) begin
          ram_we    = 1'b1;
          state_nxt = flng_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = flng_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (state_r == flng_pkg::ST_CLR) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
    end else if (state_r == flng_pkg::ST_WR && wr_go) begin
      wp_r <= ({1'b0, wpw_r} + LW'(1) >= cfg.len) ? '0 : (wpw_r + AW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == flng_pkg::ST_WR && wr_go) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      wpw_r    <= wp_eff;
      rpi_r    <= rp_full[PW-1:FB];
      frac_r   <= rp_full[FB-1:0];
      sample_r <= in_ch.sample_in;
    end
    if (state_r == flng_pkg::ST_RDB) begin
      a_r <= ram_rdata;
    end
    if (state_r == flng_pkg::ST_INT) begin
      y_r <= y_full[SW-1:0];
    end
    if (state_r == flng_pkg::ST_FB) begin
      fbp_r <= y_r * cfg.gain;
    end
    if (state_r == flng_pkg::ST_WR && wr_go) begin
      out_data_r <= y_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;

endmodule

### src/flng_ram.sv
// Generic single-write, single-read RAM with registered read data.
module flng_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/flng_cfg.sv
// APB register file: line length and feedback gain.
module flng_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [flng_pkg::PADDR_W-1:0]  paddr,
  input  logic [flng_pkg::PDATA_W-1:0]  pwdata,
  output logic [flng_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output flng_pkg::cfg_t                cfg
);

  logic [flng_pkg::LEN_W-1:0]         len_r;
  logic signed [flng_pkg::GAIN_W-1:0] gain_r;
  logic                               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= flng_pkg::LEN_RESET;
      gain_r <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        flng_pkg::REG_LINE_LENGTH:   len_r  <= pwdata[flng_pkg::LEN_W-1:0];
        flng_pkg::REG_FEEDBACK_GAIN: gain_r <= pwdata[flng_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      flng_pkg::REG_LINE_LENGTH:
        prdata = flng_pkg::PDATA_W'(len_r);
      flng_pkg::REG_FEEDBACK_GAIN:
        prdata = flng_pkg::PDATA_W'($unsigned(gain_r));
      default:
        prdata = '0;
    endcase
  end

  always_comb begin
    if (len_r < flng_pkg::LEN_MIN) begin
      cfg.len = flng_pkg::LEN_MIN;
    end else if (len_r > flng_pkg::LEN_MAX) begin
      cfg.len = flng_pkg::LEN_MAX;
    end else begin
      cfg.len = len_r;
    end
    cfg.gain = gain_r;
  end

endmodule

### tb/flng_checker.sv
// Flanger scoreboard: snoops the channels and APB writes, predicts each result and compares.
module flng_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  flng_in_if                            in_mon,
  flng_out_if                           out_mon,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [flng_pkg::PADDR_W-1:0]  paddr,
  input  logic [flng_pkg::PDATA_W-1:0]  pwdata,
  output int                            errors,
  output int                            pending
);

  localparam int REPORT_MAX = 10;
  localparam int SW         = flng_pkg::SAMPLE_W;
  localparam int FB         = flng_pkg::FRAC_BITS;

  logic        [flng_pkg::LEN_W-1:0]  len_shadow;
  logic signed [flng_pkg::GAIN_W-1:0] gain_shadow;
  logic signed [SW-1:0]               line_mem [flng_pkg::DEPTH];
  int unsigned                        head;
  logic signed [SW-1:0]               expected_q [$];

  // One sample through the delay line; updates the mirrored line and head.
  function automatic logic signed [SW-1:0] flange_step(
    logic signed [SW-1:0]                dry,
    logic        [flng_pkg::DELAY_W-1:0] dly
  );
    int unsigned span, span_q, lag, head_q, tap_q, tap, phase_frac;
    longint      near, far, wet, fb_sum;
    span = len_shadow;
    if (span < 2) span = 2;
    if (span > flng_pkg::DEPTH) span = flng_pkg::DEPTH;
    // length shrank under the head: restart at the bottom
    if (head >= span) head = 0;
    span_q = span << FB;
    lag    = dly;
    if (lag > span_q) lag = span_q;
    head_q = head << FB;
    tap_q  = (head_q >= lag) ? head_q - lag : head_q + span_q - lag;
    if (tap_q >= span_q) tap_q -= span_q;
    tap        = tap_q >> FB;
    phase_frac = tap_q & ((1 << FB) - 1);
    if (tap >= span) tap = 0;
    near = line_mem[tap];
    far  = (tap != span - 1) ? line_mem[tap + 1] : line_mem[0];
    wet  = near + ((longint'(phase_frac) * (far - near)) >>> FB);
    fb_sum = longint'(dry) + ((wet * longint'(gain_shadow)) >>> 15);
    if (fb_sum > 32767) fb_sum = 32767;
    if (fb_sum < -32768) fb_sum = -32768;
    line_mem[head] = SW'(fb_sum);
    head = (head + 1 >= span) ? 0 : head + 1;
    return SW'(wet);
  endfunction

  always @(posedge clk) begin
    logic signed [SW-1:0] want;
    if (!rst_n) begin
      for (int i = 0; i < flng_pkg::DEPTH; i++) line_mem[i] = '0;
      head        = 0;
      len_shadow  = flng_pkg::LEN_RESET;
      gain_shadow = '0;
      expected_q.delete();
      errors      = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == flng_pkg::REG_LINE_LENGTH) len_shadow = pwdata[flng_pkg::LEN_W-1:0];
        else gain_shadow = pwdata[flng_pkg::GAIN_W-1:0];
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          if (errors < REPORT_MAX)
            $display("flng_checker: unexpected result beat, sample_out=%0d",
                     out_mon.sample_out);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_mon.sample_out !== want) begin
            if (errors < REPORT_MAX)
              $display("flng_checker: sample_out mismatch, expected %0d got %0d",
                       want, out_mon.sample_out);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(flange_step(in_mon.sample_in, in_mon.delay_samples));
    end
    pending <= expected_q.size();
  end

endmodule

### tb/tb_top.sv
// Top of the flanger testbench: clock, reset, APB setup, beat traffic and the verdict.
module tb_top;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 12;
  localparam int PHASES      = 12;
  localparam int PHASE_BEATS = 150;
  localparam int LONG_HOLD   = 300;
  localparam int SW          = flng_pkg::SAMPLE_W;
  localparam int DW          = flng_pkg::DELAY_W;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          psel, penable, pwrite, pready;
  logic [flng_pkg::PADDR_W-1:0]  paddr;
  logic [flng_pkg::PDATA_W-1:0]  pwdata, prdata;

  flng_in_if  in_ch ();
  flng_out_if out_ch ();

  int          errors, pending;
  int          cycles = 0;
  int          src_gap_pct = 0;
  int          rx_stall_pct = 0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int unsigned span = flng_pkg::DEPTH;

  interpolated_feedback_flanger_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  flng_checker chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // the task idles with psel low after the access phase, keeping back-to-back writes apart
  task automatic write_reg(logic idx, logic [flng_pkg::PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // upper bits are junk on purpose; only the low 13 bits are the register
  task automatic set_length(int unsigned v);
    write_reg(flng_pkg::REG_LINE_LENGTH, ($urandom() & 32'hFFFF_E000) | (v & 32'h1FFF));
    span = v & 32'h1FFF;
    if (span < 2) span = 2;
    if (span > flng_pkg::DEPTH) span = flng_pkg::DEPTH;
  endtask

  task automatic set_gain(int v);
    write_reg(flng_pkg::REG_FEEDBACK_GAIN, {16'h0000, 16'(v)});
  endtask

  task automatic send(logic signed [SW-1:0] s, logic [DW-1:0] d);
    if (src_gap_pct > 0)
      while ($urandom_range(0, 99) < src_gap_pct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    in_ch.valid         <= 1'b1;
    in_ch.sample_in     <= s;
    in_ch.delay_samples <= d;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait until every predicted result has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] pick_delay();
    int unsigned full;
    full = span << flng_pkg::FRAC_BITS;
    case ($urandom_range(0, 19))
      0:       return DW'($urandom_range(0, (1 << DW) - 1));
      1:       return DW'(full);
      2:       return '0;
      default: return DW'($urandom_range(0, full));
    endcase
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return SW'($urandom());
    endcase
  endfunction

  initial begin
    int unsigned len_pick;
    int          gain_pick;
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_ch.valid         = 1'b0;
    in_ch.sample_in     = '0;
    in_ch.delay_samples = '0;
    out_ch.ready        = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: shortest line, full positive feedback, saturation, clamped delays
    set_length(0);
    set_gain(32767);
    send(16'sh7FFF, 21'd0);
    send(16'sh7FFF, 21'd0);
    send(16'sh7FFF, 21'd0);
    send(16'sh8000, 21'h1FFFFF);
    send(16'sh8000, 21'd512);
    send(16'sd12345, 21'd128);
    send(-16'sd1, 21'd1);
    send(16'sd0, 21'd255);
    drain();
    set_gain(-32768);
    send(16'sh7FFF, 21'd0);
    send(16'sh7FFF, 21'd0);
    send(16'sh8000, 21'd256);
    send(16'sh8000, 21'd0);
    send(16'sd100, 21'h100000);
    drain();
    set_length(8191);
    set_gain(16384);
    send(16'sd1000, 21'd0);
    send(-16'sd2000, 21'd256);
    send(16'sd3000, 21'd1);
    send(16'sd4000, 21'h100000);
    send(-16'sd5000, 21'h0FFFFF);
    drain();
    // head sits past the new length here
    set_length(3);
    send(-16'sd20000, 21'd384);
    send(16'sd20000, 21'd767);
    send(16'sd7, 21'd768);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: len_pick = 2;
        1: len_pick = flng_pkg::DEPTH;
        2: len_pick = 8191;
        default:
          case ($urandom_range(0, 9))
            0:       len_pick = $urandom_range(0, 1);
            1:       len_pick = $urandom_range(flng_pkg::DEPTH + 1, 8191);
            2:       len_pick = $urandom_range(301, flng_pkg::DEPTH);
            3, 4:    len_pick = $urandom_range(17, 300);
            default: len_pick = $urandom_range(2, 16);
          endcase
      endcase
      case ($urandom_range(0, 5))
        0:       gain_pick = -32768;
        1:       gain_pick = 32767;
        2:       gain_pick = 0;
        default: gain_pick = int'($urandom_range(0, 65535)) - 32768;
      endcase
      set_length(len_pick);
      set_gain(gain_pick);
      case (p % 4)
        0: begin src_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin src_gap_pct = 45; rx_stall_pct = 0;  end
        2: begin src_gap_pct = 0;  rx_stall_pct = 45; end
        default: begin src_gap_pct = 35; rx_stall_pct = 35; end
      endcase
      if (p == 4) hold_go = 1'b1;
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (p == 5 && i == PHASE_BEATS / 2) drain();
        send(pick_sample(), pick_delay());
      end
    end
    drain();

    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
src/flng_pkg.sv
src/flng_if.sv
src/flng_ram.sv
src/flng_cfg.sv
src/interpolated_feedback_flanger_core.sv
tb/flng_checker.sv
tb/tb_top.sv
